@@ rtl/lpqsd_pkg.sv @@
// Shared types and constants for the quarter-scan LED panel driver.
// No dependencies; imported by every module of the block.
`default_nettype none

package lpqsd_pkg;

  localparam int FRAME_ROWS  = 16;
  localparam int ROW_BYTES   = 4;
  localparam int GROUPS      = FRAME_ROWS / 4;
  localparam int PHASE_BYTES = ROW_BYTES * GROUPS;
  localparam int FRAME_DEPTH = FRAME_ROWS * ROW_BYTES;

  localparam int ROW_W  = $clog2(FRAME_ROWS);
  localparam int COL_W  = $clog2(ROW_BYTES);
  localparam int GRP_W  = $clog2(GROUPS);
  localparam int ADDR_W = $clog2(FRAME_DEPTH);
  localparam int BC_W   = $clog2(PHASE_BYTES);
  localparam int TIME_W = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [TIME_W-1:0] ON_TIME_RST = TIME_W'(200);
  localparam logic [TIME_W-1:0] PERIOD_RST  = TIME_W'(1000);

  localparam logic [2:0]      BIT_LAST = 3'd7;
  localparam logic [BC_W-1:0] BC_LAST  = BC_W'(PHASE_BYTES - 1);
  localparam logic [1:0]      ROW_SEL_MAX = 2'd3;

  localparam logic [1:0] ST_SHIFT = 2'd0;
  localparam logic [1:0] ST_LATCH = 2'd1;
  localparam logic [1:0] ST_LIT   = 2'd2;
  localparam logic [1:0] ST_DARK  = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ON_TIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 1'b1;

  typedef struct packed {
    logic       op;
    logic [3:0] row;
    logic [1:0] byte_col;
    logic [7:0] pixel_byte;
  } in_word_t;

  typedef struct packed {
    logic       serial_data;
    logic       shift_clock;
    logic       latch_clock;
    logic [1:0] row_select;
    logic       output_enable;
  } out_word_t;

  typedef struct packed {
    logic [TIME_W-1:0] on_time;
    logic [TIME_W-1:0] period;
  } timing_cfg_t;

endpackage

`default_nettype wire

@@ rtl/lpqsd_frame_ram.sv @@
// Frame store: one write port, one registered read port with write bypass.
// Per-entry valid bits clear at reset so unwritten bytes read as zero.
// Depends on lpqsd_pkg.
`default_nettype none

module lpqsd_frame_ram
  import lpqsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]        wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]             rd_data
);

  logic [7:0]             mem [FRAME_DEPTH];
  logic [FRAME_DEPTH-1:0] valid_r;
  logic [7:0]             rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else if (valid_r[rd_addr]) begin
      rd_data_r <= mem[rd_addr];
    end else begin
      rd_data_r <= '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/lpqsd_scan_core.sv @@
// Scan sequencer: shift, latch, lit and dark stages, pin levels per tick.
// Computes the frame address of the byte the next tick will send.
// Depends on lpqsd_pkg.
`default_nettype none

module lpqsd_scan_core
  import lpqsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire timing_cfg_t       cfg,
  input  wire logic [7:0]        frame_byte,
  output logic [ADDR_W-1:0]      rd_addr,
  output out_word_t              pins
);

  logic [1:0]        stage_r, stage_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [BC_W-1:0]   bc_r, bc_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic              hs_r, hs_nxt;
  logic [TIME_W-1:0] tc_r, tc_nxt;
  out_word_t         pins_r, pins_nxt;

  logic [TIME_W-1:0] dark;
  logic              wrap;
  logic              shift0;
  logic [2:0]        bit_idx;
  logic [7:0]        byte_inv;
  logic [1:0]        phase_eff;
  logic [GRP_W-1:0]  grp;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  frame_row;

  assign dark     = (cfg.period > cfg.on_time) ? (cfg.period - cfg.on_time) : '0;
  assign byte_inv = ~frame_byte;

  always_comb begin
    stage_nxt = stage_r;
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    bit_nxt   = bit_r;
    hs_nxt    = hs_r;
    tc_nxt    = tc_r;
    pins_nxt  = pins_r;
    wrap      = 1'b0;
    shift0    = 1'b0;
    bit_idx   = bit_r;
    if (step) begin
      case (stage_r)
        ST_SHIFT: begin
          if (!hs_r) begin
            shift0 = 1'b1;
          end else begin
            pins_nxt.shift_clock = 1'b1;
            hs_nxt = 1'b0;
            if (bit_r == BIT_LAST) begin
              bit_nxt   = '0;
              stage_nxt = ST_LATCH;
            end else begin
              bit_nxt = bit_r + 3'd1;
            end
          end
        end
        ST_LATCH: begin
          if (!hs_r) begin
            pins_nxt.latch_clock = 1'b0;
            hs_nxt = 1'b1;
          end else begin
            pins_nxt.latch_clock = 1'b1;
            hs_nxt = 1'b0;
            if (bc_r == BC_LAST) begin
              bc_nxt    = '0;
              stage_nxt = ST_LIT;
              tc_nxt    = '0;
            end else begin
              bc_nxt    = bc_r + BC_W'(1);
              stage_nxt = ST_SHIFT;
            end
          end
        end
        ST_LIT: begin
          pins_nxt.row_select = ROW_SEL_MAX - phase_r;
          if (tc_r < cfg.on_time) begin
            pins_nxt.output_enable = 1'b1;
            tc_nxt = tc_r + TIME_W'(1);
          end else if (dark != '0) begin
            pins_nxt.output_enable = 1'b0;
            stage_nxt = ST_DARK;
            tc_nxt    = TIME_W'(1);
          end else begin
            wrap = 1'b1;
          end
        end
        ST_DARK: begin
          pins_nxt.row_select    = ROW_SEL_MAX - phase_r;
          pins_nxt.output_enable = 1'b0;
          if (tc_r >= dark) begin
            wrap = 1'b1;
          end else begin
            tc_nxt = tc_r + TIME_W'(1);
          end
        end
        default: begin
          stage_nxt = ST_SHIFT;
        end
      endcase
      if (wrap) begin
        pins_nxt.output_enable = 1'b0;
        tc_nxt    = '0;
        phase_nxt = phase_r + 2'd1;
        stage_nxt = ST_SHIFT;
        bc_nxt    = '0;
        bit_nxt   = '0;
        bit_idx   = 3'd0;
        shift0    = 1'b1;
      end
      if (shift0) begin
        pins_nxt.serial_data = byte_inv[BIT_LAST - bit_idx];
        pins_nxt.shift_clock = 1'b0;
        hs_nxt = 1'b1;
      end
    end
  end

  // fetch for the next tick: lit and dark stages lead into the next phase
  assign phase_eff = ((stage_nxt == ST_LIT) || (stage_nxt == ST_DARK)) ?
                     (phase_nxt + 2'd1) : phase_nxt;
  assign grp       = bc_nxt[GRP_W-1:0];
  assign col       = COL_W'(bc_nxt >> GRP_W);
  assign frame_row = ROW_W'(FRAME_ROWS - 1) - ROW_W'(phase_eff)
                   - (ROW_W'(grp) << 2);
  assign rd_addr   = ADDR_W'(frame_row) * ADDR_W'(ROW_BYTES) + ADDR_W'(col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= ST_SHIFT;
      phase_r <= '0;
      bc_r    <= '0;
      bit_r   <= '0;
      hs_r    <= 1'b0;
      tc_r    <= '0;
      pins_r  <= '0;
    end else begin
      stage_r <= stage_nxt;
      phase_r <= phase_nxt;
      bc_r    <= bc_nxt;
      bit_r   <= bit_nxt;
      hs_r    <= hs_nxt;
      tc_r    <= tc_nxt;
      pins_r  <= pins_nxt;
    end
  end

  assign pins = pins_r;

`ifndef SYNTHESIS
  a_latch_bits_done: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_r == ST_LATCH) |-> (bit_r == '0))
    else $error("latch stage entered with bits pending");

  a_hold_counters_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((stage_r == ST_LIT) || (stage_r == ST_DARK)) |-> ((bc_r == '0) && !hs_r))
    else $error("byte or half-step count left over after shifting");

  a_oe_only_lit: assert property (@(posedge clk) disable iff (!rst_n)
    pins_r.output_enable |-> (stage_r == ST_LIT))
    else $error("output enable high outside lit stage");

  a_clock_rises: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (stage_r == ST_SHIFT) && hs_r) |=> pins_r.shift_clock)
    else $error("shift clock did not rise on second half step");
`endif

endmodule

`default_nettype wire

@@ rtl/led_panel_quarter_scan_driver_top.sv @@
// Tick words pass the input register, then the scan core's pin register, to the output.
// Throughput: one word per cycle, frame writes and ticks alike, while out_ready is high.
// The next tick's frame byte is fetched ahead of it from a registered memory port.
// Reset (rst_n low, synchronous) clears the scan state, pins and the frame store's
// per-byte valid bits and loads the timing registers with defaults; no clearing pass is needed.
// Depends on lpqsd_pkg, lpqsd_frame_ram and lpqsd_scan_core.
`default_nettype none

module led_panel_quarter_scan_driver_top
  import lpqsd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_word_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_word_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TIME_W-1:0]    cfg_wdata
);

  in_word_t          in_r;
  logic              in_valid_r;
  logic              out_valid_r;
  timing_cfg_t       cfg_r;
  logic              advance;
  logic              tick_adv;
  logic              wr_adv;
  logic              wr_in_range;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        frame_byte;
  out_word_t         pins;

  assign advance  = in_valid_r && ((in_r.op == OP_WRITE) || !out_valid_r || out_ready);
  assign tick_adv = advance && (in_r.op == OP_TICK);
  assign in_ready = !in_valid_r || advance;

  assign wr_in_range = (int'(in_r.row) < FRAME_ROWS) && (int'(in_r.byte_col) < ROW_BYTES);
  assign wr_adv      = advance && (in_r.op == OP_WRITE) && wr_in_range;
  assign wr_addr     = ADDR_W'(in_r.row) * ADDR_W'(ROW_BYTES) + ADDR_W'(in_r.byte_col);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (tick_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_time <= ON_TIME_RST;
      cfg_r.period  <= PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ON_TIME: cfg_r.on_time <= cfg_wdata;
        CFG_PERIOD:  cfg_r.period  <= cfg_wdata;
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  lpqsd_frame_ram u_frame_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_adv),
    .wr_addr (wr_addr),
    .wr_data (in_r.pixel_byte),
    .rd_addr (rd_addr),
    .rd_data (frame_byte)
  );

  lpqsd_scan_core u_scan_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (tick_adv),
    .cfg        (cfg_r),
    .frame_byte (frame_byte),
    .rd_addr    (rd_addr),
    .pins       (pins)
  );

  assign out_valid = out_valid_r;
  assign out_data  = pins;

`ifndef SYNTHESIS
  a_tick_held_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && (in_r.op == OP_TICK) && out_valid_r && !out_ready) |-> !in_ready)
    else $error("tick word taken while result word still pending");

  a_pins_stable_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(pins))
    else $error("pin levels changed under a pending result word");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (in_r.op == OP_WRITE) && !out_valid_r) |=> !out_valid_r)
    else $error("frame write produced a result word");
`endif

endmodule

`default_nettype wire

@@ tb/sv/lpqsd_scan_check_pkg.sv @@
// Scoreboard for the quarter-scan LED panel driver: pin-level predictor and result checker.
// Depends on lpqsd_pkg for the word types, timing widths, stage and register codes.
`timescale 1ns / 100ps

package lpqsd_scan_check_pkg;
  import lpqsd_pkg::*;

  class panel_scan_scoreboard;
    logic [7:0]        frame [FRAME_DEPTH];
    logic [1:0]        phase;
    int unsigned       byte_cnt;
    int unsigned       bit_cnt;
    bit                half;
    logic [1:0]        stage;
    int unsigned       time_cnt;
    out_word_t         pins;
    logic [TIME_W-1:0] on_time;
    logic [TIME_W-1:0] period;
    out_word_t         pins_due [$];
    int unsigned       mismatches;
    int unsigned       checked;

    function new();
      foreach (frame[i]) frame[i] = 8'h00;
      phase      = 2'd0;
      byte_cnt   = 0;
      bit_cnt    = 0;
      half       = 1'b0;
      stage      = ST_SHIFT;
      time_cnt   = 0;
      pins       = '0;
      on_time    = ON_TIME_RST;
      period     = PERIOD_RST;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] value);
      case (idx)
        CFG_ON_TIME: on_time = value;
        CFG_PERIOD:  period = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return pins_due.size();
    endfunction

    // Inverted pixel bit of the byte now being shifted, MSB first.
    function logic pixel_bit();
      int grp;
      int col;
      int r;
      col = byte_cnt / GROUPS;
      grp = byte_cnt % GROUPS;
      r = FRAME_ROWS - (int'(phase) + 1) - 4 * grp;
      return ~frame[r * ROW_BYTES + col][7 - bit_cnt];
    endfunction

    function void advance_scan();
      int unsigned dark;
      bit settled;
      settled = 1'b0;
      while (!settled) begin
        case (stage)
          ST_SHIFT: begin
            if (!half) begin
              pins.serial_data = pixel_bit();
              pins.shift_clock = 1'b0;
              half = 1'b1;
            end else begin
              pins.shift_clock = 1'b1;
              half = 1'b0;
              bit_cnt++;
              if (bit_cnt >= 8) begin
                bit_cnt = 0;
                stage = ST_LATCH;
              end
            end
            settled = 1'b1;
          end
          ST_LATCH: begin
            if (!half) begin
              pins.latch_clock = 1'b0;
              half = 1'b1;
            end else begin
              pins.latch_clock = 1'b1;
              half = 1'b0;
              byte_cnt++;
              if (byte_cnt >= PHASE_BYTES) begin
                byte_cnt = 0;
                stage = ST_LIT;
                time_cnt = 0;
              end else begin
                stage = ST_SHIFT;
              end
            end
            settled = 1'b1;
          end
          ST_LIT: begin
            pins.row_select = ROW_SEL_MAX - phase;
            if (time_cnt >= on_time) begin
              stage = ST_DARK;
              time_cnt = 0;
            end else begin
              pins.output_enable = 1'b1;
              time_cnt++;
              settled = 1'b1;
            end
          end
          default: begin
            dark = (period > on_time) ? period - on_time : 0;
            pins.row_select = ROW_SEL_MAX - phase;
            pins.output_enable = 1'b0;
            if (time_cnt >= dark) begin
              time_cnt = 0;
              phase = phase + 2'd1;
              stage = ST_SHIFT;
              half = 1'b0;
              bit_cnt = 0;
              byte_cnt = 0;
            end else begin
              time_cnt++;
              settled = 1'b1;
            end
          end
        endcase
      end
    endfunction

    function void note_word(in_word_t w);
      if (w.op == OP_WRITE) begin
        if (w.row < FRAME_ROWS && w.byte_col < ROW_BYTES)
          frame[w.row * ROW_BYTES + w.byte_col] = w.pixel_byte;
      end else begin
        advance_scan();
        pins_due.push_back(pins);
      end
    endfunction

    function void check_pins(out_word_t got);
      out_word_t want;
      checked++;
      if (pins_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pin word %0d: ds=%b sck=%b lat=%b row=%0d oe=%b", checked,
                   got.serial_data, got.shift_clock, got.latch_clock, got.row_select,
                   got.output_enable);
        return;
      end
      want = pins_due.pop_front();
      if (got.serial_data !== want.serial_data || got.shift_clock !== want.shift_clock ||
          got.latch_clock !== want.latch_clock || got.row_select !== want.row_select ||
          got.output_enable !== want.output_enable) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pin word %0d: expected %b/%b/%b/%0d/%b, got %b/%b/%b/%0d/%b",
                   checked, want.serial_data, want.shift_clock, want.latch_clock,
                   want.row_select, want.output_enable, got.serial_data, got.shift_clock,
                   got.latch_clock, got.row_select, got.output_enable);
      end
    endfunction
  endclass

endpackage

@@ tb/sv/tb_led_panel_quarter_scan_driver_top.sv @@
// Testbench for led_panel_quarter_scan_driver_top: frame writes and scan ticks under
// random idling and timing settings, each pin word checked against a predictor.
// Depends on lpqsd_pkg, lpqsd_scan_check_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_led_panel_quarter_scan_driver_top;
  import lpqsd_pkg::*;
  import lpqsd_scan_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          TICK_PCT    = 85;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_word_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TIME_W-1:0]    cfg_wdata;

  panel_scan_scoreboard board = new();
  bit                   calm = 1'b0;
  bit                   long_hold_done = 1'b0;
  int unsigned          cycle_count = 0;

  led_panel_quarter_scan_driver_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_pins(out_data);
  end

  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (!calm && !long_hold_done && board.checked >= 300) begin
        out_ready <= 1'b0;
        repeat (90) @(negedge clk);
        long_hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 25)) @(negedge clk);
      end
    end
  end

  // Enter and leave at a falling edge.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = (!calm && $urandom_range(0, 6) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    board.note_word(w);
    @(negedge clk);
  endtask

  function automatic in_word_t random_word(int tick_pct);
    in_word_t w;
    w.op         = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_WRITE;
    w.row        = 4'($urandom_range(0, 15));
    w.byte_col   = 2'($urandom_range(0, 3));
    w.pixel_byte = 8'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic in_word_t frame_write(logic [3:0] r, logic [1:0] c, logic [7:0] b);
    in_word_t w;
    w.op = OP_WRITE;
    w.row = r;
    w.byte_col = c;
    w.pixel_byte = b;
    return w;
  endfunction

  // Drain, let trailing writes settle, then update both timing registers.
  task automatic write_timing(input logic [TIME_W-1:0] on_val, input logic [TIME_W-1:0] per_val);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ON_TIME;
    cfg_wdata <= on_val;
    board.write_reg(CFG_ON_TIME, on_val);
    @(negedge clk);
    cfg_index <= CFG_PERIOD;
    cfg_wdata <= per_val;
    board.write_reg(CFG_PERIOD, per_val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [TIME_W-1:0] on_val, input logic [TIME_W-1:0] per_val,
                           input int n);
    write_timing(on_val, per_val);
    repeat (n) send_word(random_word(TICK_PCT));
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_ON_TIME;
    cfg_wdata = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // First bytes of the first scan phase, plus extreme patterns elsewhere.
    send_word(frame_write(4'd15, 2'd0, 8'hFF));
    send_word(frame_write(4'd11, 2'd0, 8'h00));
    send_word(frame_write(4'd7, 2'd0, 8'h80));
    send_word(frame_write(4'd3, 2'd0, 8'h01));
    send_word(frame_write(4'd0, 2'd3, 8'hA5));
    send_word(frame_write(4'd14, 2'd1, 8'h5A));
    send_word(frame_write(4'd12, 2'd2, 8'h7E));
    send_word(frame_write(4'd13, 2'd3, 8'hC3));
    repeat (16) send_word(random_word(100));

    run_phase(12'd0, 12'd0, 250);
    run_phase(12'd0, 12'd1, 200);
    run_phase(12'd3, 12'd9, 250);
    run_phase(12'd4095, 12'd1, 120);
    run_phase(12'd2, 12'd4095, 80);
    run_phase(12'($urandom_range(0, 20)), 12'($urandom_range(0, 40)), 250);
    calm = 1'b1;
    run_phase(12'd5, 12'd5, 300);

    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
